### rtl/s1md_pkg.sv
// s1md_pkg: shared types and constants for the SHA-1 message digest block.
// No dependencies.
`timescale 1ns / 1ps
package s1md_pkg;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  // Classified item passed from the front end to the core.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } item_t;

  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] r;
    begin
      case (idx)
        3'd0: r = H0;
        3'd1: r = H1;
        3'd2: r = H2;
        3'd3: r = H3;
        default: r = H4;
      endcase
      return r;
    end
  endfunction

endpackage

### rtl/s1md_front.sv
// s1md_front: input front end, drops empty items and queues the rest.
// Depends on s1md_pkg.
`timescale 1ns / 1ps
module s1md_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              has_byte_i,
  input  logic              is_last_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output s1md_pkg::item_t   q_item_o
);
  // two-entry queue
  s1md_pkg::item_t mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop, useful;

  assign useful     = has_byte_i | is_last_i;
  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i & ~in_stall_o & useful;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i & q_valid_o;
  assign q_item_o   = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q ^ push;
    rp_d  = rp_q ^ pop;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= '{data_byte: data_byte_i, has_byte: has_byte_i, is_last: is_last_i};
    end
  end
endmodule

### rtl/s1md_core.sv
// s1md_core: back end; packs bytes, pads, runs 80 rounds, emits digest.
// Depends on s1md_pkg.
`timescale 1ns / 1ps
module s1md_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_pop_o,
  input  s1md_pkg::item_t   q_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       digest_word_o,
  output logic [2:0]        word_index_o,
  output logic              last_word_o
);
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PAD   = 7'b0000010,
    ST_ZERO  = 7'b0000100,
    ST_LEN   = 7'b0001000,
    ST_ROUND = 7'b0010000,
    ST_FOLD  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e      st_q, st_d;
  logic [31:0] w_q [16];
  logic [31:0] h_q [5];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [5:0]  pos_q;
  logic [63:0] bits_q;
  logic [6:0]  rnd_q;
  logic        fin_q;   // this compression belongs to padding
  logic        len_q;   // length still to be written after this block
  logic [2:0]  oidx_q;
  logic        pend_last_q;   // last item whose byte filled a block

  logic [3:0]  t4;
  logic [31:0] wx, wt, f, k, tmp;
  logic        do_byte;
  logic [7:0]  byte_in;
  logic [1:0]  bsel;
  logic [3:0]  widx;

  assign t4 = rnd_q[3:0];
  assign wx = w_q[t4 - 4'd3] ^ w_q[t4 - 4'd8] ^ w_q[t4 - 4'd14] ^ w_q[t4];
  assign wt = (rnd_q < 7'd16) ? w_q[t4] : {wx[30:0], wx[31]};

  always_comb begin
    if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q); k = s1md_pkg::K0;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q; k = s1md_pkg::K1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = s1md_pkg::K2;
    end else begin
      f = b_q ^ c_q ^ d_q; k = s1md_pkg::K3;
    end
  end
  assign tmp = {a_q[26:0], a_q[31:27]} + f + e_q + wt + k;

  assign q_pop_o = (st_q == ST_IDLE) & q_valid_i;
  assign do_byte = (q_pop_o & q_item_i.has_byte) | (st_q == ST_PAD);
  assign byte_in = (st_q == ST_PAD) ? s1md_pkg::PAD_BYTE : q_item_i.data_byte;
  assign bsel = pos_q[1:0];
  assign widx = pos_q[5:2];

  assign out_valid_o   = (st_q == ST_OUT);
  assign digest_word_o = h_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd4);

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (q_pop_o) begin
        if (q_item_i.has_byte && pos_q == 6'd63) st_d = ST_ROUND;
        else if (q_item_i.is_last) st_d = ST_PAD;
      end
      ST_PAD:   st_d = (pos_q == 6'd63) ? ST_ROUND : ST_ZERO;
      // word 14 byte 0 starts the length; word 15 ends a block with no room for the length
      ST_ZERO:  if (pos_q[5:2] == 4'd14 && pos_q[1:0] == 2'd0) st_d = ST_LEN;
                else if (pos_q[5:2] == 4'd15) st_d = ST_ROUND;
      ST_LEN:   st_d = ST_ROUND;
      ST_ROUND: if (rnd_q == 7'd79) st_d = ST_FOLD;
      ST_FOLD:  st_d = len_q ? ST_ZERO : (fin_q ? ST_OUT : (pend_last_q ? ST_PAD : ST_IDLE));
      ST_OUT:   if (!out_stall_i && oidx_q == 3'd4) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; pos_q <= '0; bits_q <= '0; rnd_q <= '0;
      fin_q <= 1'b0; len_q <= 1'b0; oidx_q <= '0; pend_last_q <= 1'b0;
      for (int i = 0; i < 5; i++) h_q[i] <= s1md_pkg::init_word(3'(i));
    end else begin
      st_q <= st_d;
      if (q_pop_o) begin
        pend_last_q <= q_item_i.is_last & q_item_i.has_byte & (pos_q == 6'd63);
        if (q_item_i.has_byte) bits_q <= bits_q + 64'd8;
      end
      if (do_byte) pos_q <= pos_q + 6'd1;
      if (st_q == ST_PAD) begin
        fin_q <= (pos_q <= 6'd55);
        len_q <= (pos_q > 6'd55);
        pend_last_q <= 1'b0;
      end
      if (st_q == ST_ZERO) pos_q <= pos_q + 6'd4 - {4'd0, pos_q[1:0]};
      if (st_q == ST_LEN) begin
        pos_q <= '0; fin_q <= 1'b1; len_q <= 1'b0;
      end
      if (st_q == ST_ROUND) begin
        rnd_q <= (rnd_q == 7'd79) ? 7'd0 : rnd_q + 7'd1;
      end
      if (st_q == ST_FOLD) begin
        h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q; h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q; h_q[4] <= h_q[4] + e_q;
        if (len_q) fin_q <= 1'b0;
      end
      if (st_q == ST_OUT && !out_stall_i) begin
        oidx_q <= (oidx_q == 3'd4) ? 3'd0 : oidx_q + 3'd1;
        if (oidx_q == 3'd4) begin
          pos_q <= '0; bits_q <= '0; fin_q <= 1'b0;
          for (int i = 0; i < 5; i++) h_q[i] <= s1md_pkg::init_word(3'(i));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_byte) begin
      case (bsel)
        2'd0: w_q[widx] <= {byte_in, 24'd0};
        2'd1: w_q[widx][23:16] <= byte_in;
        2'd2: w_q[widx][15:8] <= byte_in;
        default: w_q[widx][7:0] <= byte_in;
      endcase
    end
    if (st_q == ST_ZERO && !(pos_q[5:2] == 4'd14 && pos_q[1:0] == 2'd0)) begin
      if (bsel == 2'd0) w_q[widx] <= '0;
    end
    if (st_q == ST_LEN) begin
      w_q[14] <= bits_q[63:32];
      w_q[15] <= bits_q[31:0];
    end
    if (st_q == ST_ROUND && rnd_q >= 7'd16) w_q[t4] <= wt;
    if (st_d == ST_ROUND && st_q != ST_ROUND) begin
      a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
    end else if (st_q == ST_ROUND) begin
      e_q <= d_q; d_q <= c_q; c_q <= {b_q[1:0], b_q[31:2]}; b_q <= a_q; a_q <= tmp;
    end
  end
endmodule

### rtl/sha1_message_digest.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_stall_o   | data_byte_i, has_byte_i, is_last_i
// out     | output    | out_valid_o/out_stall_i | digest_word_o, word_index_o, last_word_o
//
// One byte is absorbed per core cycle while the core is idle; a full block is then
// compressed by the single round unit and folded in before more bytes are taken.
// A final item adds padding (0x80 marker, zero fill, 64-bit length) in one or two
// compressions, then five output transactions. A two-entry queue decouples the input.
// Reset is asynchronous, active low; out stalls hold the current digest word.
// Depends on s1md_pkg, s1md_front, s1md_core.
`timescale 1ns / 1ps
module sha1_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  logic            q_valid, q_pop;
  s1md_pkg::item_t q_item;

  // front end: filters empty items, holds up to two transactions
  s1md_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i, .has_byte_i,
    .is_last_i, .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  // back end: packing, padding, compression and digest output
  s1md_core u_core (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .out_valid_o, .out_stall_i, .digest_word_o, .word_index_o, .last_word_o
  );
endmodule

### rtl/s1md_checker.sv
// s1md_checker: port-level checks for sha1_message_digest, bound to the top.
// Depends on sha1_message_digest ports only.
`timescale 1ns / 1ps
module s1md_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digest_word_o))
    else $error("stalled digest word changed");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 3'd4)))
    else $error("last flag wrong");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> word_index_o <= 3'd4)
    else $error("index out of range");
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_word_o |=>
      out_valid_o && word_index_o == $past(word_index_o) + 3'd1)
    else $error("digest words not consecutive");
endmodule

bind sha1_message_digest s1md_checker u_chk (.*);
